[hw/rtl/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, opcode and function codes, and stage structs for the
// MIPS integer subset execute block.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int unsigned DATA_WORDS_DEF = 1024;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned PC_W           = 26;
    localparam int unsigned REG_AW         = 5;
    localparam int unsigned REG_NUM        = 32;
    localparam int unsigned SIDX_W         = 10;
    localparam int unsigned LIDX_W         = 10;
    localparam int unsigned WADDR_W        = 30;
    localparam int unsigned RES_DEPTH      = 4;
    localparam int unsigned RES_PW         = 2;
    localparam int unsigned RES_CW         = 3;

    // primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_J     = 6'b000010;
    localparam logic [5:0] OP_JAL   = 6'b000011;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_BNE   = 6'b000101;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_ADDIU = 6'b001001;
    localparam logic [5:0] OP_SLTI  = 6'b001010;
    localparam logic [5:0] OP_SLTIU = 6'b001011;
    localparam logic [5:0] OP_ANDI  = 6'b001100;
    localparam logic [5:0] OP_ORI   = 6'b001101;
    localparam logic [5:0] OP_LUI   = 6'b001111;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;

    // function codes for register-type instructions
    localparam logic [5:0] FN_SLL  = 6'b000000;
    localparam logic [5:0] FN_SRL  = 6'b000010;
    localparam logic [5:0] FN_ADD  = 6'b100000;
    localparam logic [5:0] FN_ADDU = 6'b100001;
    localparam logic [5:0] FN_SUB  = 6'b100010;
    localparam logic [5:0] FN_SUBU = 6'b100011;
    localparam logic [5:0] FN_AND  = 6'b100100;
    localparam logic [5:0] FN_OR   = 6'b100101;
    localparam logic [5:0] FN_SLT  = 6'b101010;
    localparam logic [5:0] FN_SLTU = 6'b101011;

    localparam logic [REG_AW-1:0] REG_LINK = 5'd31;

    // execute stage outcome
    typedef struct packed {
        logic [PC_W-1:0]    npc;
        logic               wr;
        logic [REG_AW-1:0]  dst;
        logic [WORD_W-1:0]  val;
        logic               lw_wb;
        logic               mem;
        logic               st;
        logic [WADDR_W-1:0] word_addr;
        logic               unk;
    } t_ex;

    // one result item
    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              wrote_reg;
        logic [REG_AW-1:0] dest_reg;
        logic [WORD_W-1:0] write_value;
        logic              stored;
        logic [SIDX_W-1:0] store_index;
        logic              unknown_op;
    } t_res;

    // (b * 2^sh) mod d, evaluated at elaboration for the index tables
    function automatic int unsigned mse_residue(int unsigned b, int unsigned sh,
                                                int unsigned d);
        int unsigned r;
        r = b;
        for (int i = 0; i < 256; i++) begin
            if (r >= d) r = r - d;
        end
        for (int k = 0; k < 32; k++) begin
            if (k < sh) begin
                r = r << 1;
                if (r >= d) r = r - d;
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/mse_if.sv]
// ----------------------------------------------------------------------------
// mse_if
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface mse_in_if;
    import mse_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [WORD_W-1:0]   instr_word;
    logic [LIDX_W-1:0]   load_index;
    logic [WORD_W-1:0]   load_value;

    modport source (output valid, mode, instr_word, load_index, load_value,
                    input ready);
    modport sink   (input valid, mode, instr_word, load_index, load_value,
                    output ready);
endinterface

interface mse_out_if;
    import mse_pkg::*;

    logic                valid;
    logic                ready;
    logic [PC_W-1:0]     next_pc;
    logic                wrote_reg;
    logic [REG_AW-1:0]   dest_reg;
    logic [WORD_W-1:0]   write_value;
    logic                stored;
    logic [SIDX_W-1:0]   store_index;
    logic                unknown_op;

    modport source (output valid, next_pc, wrote_reg, dest_reg, write_value, stored,
                    store_index, unknown_op, input ready);
    modport sink   (input valid, next_pc, wrote_reg, dest_reg, write_value, stored,
                    store_index, unknown_op, output ready);
endinterface

[hw/rtl/mips_subset_execute.sv]
// ----------------------------------------------------------------------------
// mips_subset_execute
// Executes one MIPS integer subset instruction, or preloads one data word,
// per input transfer, keeping program counter, registers and data store.
// ----------------------------------------------------------------------------
// path: each item is registered through execute, writeback and the result queue
// throughput: one item per cycle; up to four items in flight, limited by the
//   result queue depth, with register results forwarded between stages
// reset: synchronous; pc and register file read as zero at once, then a
//   clearing pass zeroes every data store word with ready low
module mips_subset_execute #(
    parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mse_in_if.sink     i_in,
    mse_out_if.source  o_out
);
    import mse_pkg::*;

    localparam int unsigned AW = $clog2(DATA_WORDS);

    // execute stage input
    logic              r_s2_vld;
    logic              r_s2_mode;
    logic [WORD_W-1:0] r_s2_instr;
    logic [LIDX_W-1:0] r_s2_lidx;
    logic [WORD_W-1:0] r_s2_lval;

    // writeback stage
    logic              r_s3_vld;
    logic              r_s3_lw;
    t_res              r_s3_res;

    // register write retired at the last edge, missed by the register read
    logic              r_ret_en;
    logic [REG_AW-1:0] r_ret_dst;
    logic [WORD_W-1:0] r_ret_val;

    logic [PC_W-1:0]   r_pc;
    logic [RES_CW-1:0] r_inflight;
    logic [RES_CW-1:0] n_inflight;

    logic              w_accept;
    logic              w_pop;
    logic              w_busy;
    logic [WORD_W-1:0] w_rf_a;
    logic [WORD_W-1:0] w_rf_b;
    logic [WORD_W-1:0] w_a;
    logic [WORD_W-1:0] w_b;
    logic [WORD_W-1:0] w_s3_val;
    logic              w_s3_we;
    logic [WORD_W-1:0] w_mem_rdata;
    logic [AW-1:0]     w_aidx;
    logic [AW-1:0]     w_lidx;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [WORD_W-1:0] w_mem_wdata;
    logic              w_fifo_vld;
    t_ex               w_ex;
    t_res              w_wb_res;
    t_res              w_out_res;

    assign i_in.ready = !w_busy && (r_inflight < RES_CW'(RES_DEPTH));
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pop      = w_fifo_vld && o_out.ready;

    always_comb begin
        n_inflight = r_inflight;
        if (w_accept && !w_pop) n_inflight = r_inflight + 1'b1;
        if (!w_accept && w_pop) n_inflight = r_inflight - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_ret_en   <= 1'b0;
            r_pc       <= '0;
            r_inflight <= '0;
        end else begin
            r_s2_vld   <= w_accept;
            r_s3_vld   <= r_s2_vld;
            r_ret_en   <= w_s3_we;
            r_inflight <= n_inflight;
            if (r_s2_vld) r_pc <= w_ex.npc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mode  <= i_in.mode;
        r_s2_instr <= i_in.instr_word;
        r_s2_lidx  <= i_in.load_index;
        r_s2_lval  <= i_in.load_value;
        r_ret_dst  <= r_s3_res.dest_reg;
        r_ret_val  <= w_s3_val;
        r_s3_lw    <= w_ex.lw_wb;
        r_s3_res.next_pc     <= w_ex.npc;
        r_s3_res.wrote_reg   <= w_ex.wr;
        r_s3_res.dest_reg    <= w_ex.dst;
        r_s3_res.write_value <= w_ex.val;
        r_s3_res.stored      <= w_ex.st;
        r_s3_res.store_index <= w_ex.mem ? SIDX_W'(w_aidx) : '0;
        r_s3_res.unknown_op  <= w_ex.unk;
    end

    // register reads are taken at the input transfer
    mse_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rs_addr (i_in.instr_word[25:21]),
        .i_rt_addr (i_in.instr_word[20:16]),
        .i_we      (w_s3_we),
        .i_waddr   (r_s3_res.dest_reg),
        .i_wdata   (w_s3_val),
        .o_rs_data (w_rf_a),
        .o_rt_data (w_rf_b)
    );

    // loads take their value from the store read in writeback
    assign w_s3_val = r_s3_lw ? w_mem_rdata : r_s3_res.write_value;
    assign w_s3_we  = r_s3_vld && r_s3_res.wrote_reg;

    // forwarding: writeback stage first, then the write retired last edge
    always_comb begin
        w_a = w_rf_a;
        w_b = w_rf_b;
        if (r_ret_en && r_ret_dst == r_s2_instr[25:21]) w_a = r_ret_val;
        if (r_ret_en && r_ret_dst == r_s2_instr[20:16]) w_b = r_ret_val;
        if (w_s3_we && r_s3_res.dest_reg == r_s2_instr[25:21]) w_a = w_s3_val;
        if (w_s3_we && r_s3_res.dest_reg == r_s2_instr[20:16]) w_b = w_s3_val;
    end

    mse_exec u_exec (
        .i_mode  (r_s2_mode),
        .i_instr (r_s2_instr),
        .i_pc    (r_pc),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_ex    (w_ex)
    );

    mse_idx_mod #(
        .IN_W  (WADDR_W),
        .DEPTH (DATA_WORDS)
    ) u_aidx (
        .i_val (w_ex.word_addr),
        .o_idx (w_aidx)
    );

    mse_idx_mod #(
        .IN_W  (LIDX_W),
        .DEPTH (DATA_WORDS)
    ) u_lidx (
        .i_val (r_s2_lidx),
        .o_idx (w_lidx)
    );

    assign w_mem_we    = r_s2_vld && (r_s2_mode || w_ex.st);
    assign w_mem_waddr = r_s2_mode ? w_lidx : w_aidx;
    assign w_mem_wdata = r_s2_mode ? r_s2_lval : w_b;

    mse_dstore #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_aidx),
        .o_rdata (w_mem_rdata),
        .o_busy  (w_busy)
    );

    always_comb begin
        w_wb_res             = r_s3_res;
        w_wb_res.write_value = w_s3_val;
    end

    mse_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_vld),
        .i_data  (w_wb_res),
        .i_pop   (w_pop),
        .o_valid (w_fifo_vld),
        .o_data  (w_out_res)
    );

    assign o_out.valid       = w_fifo_vld;
    assign o_out.next_pc     = w_out_res.next_pc;
    assign o_out.wrote_reg   = w_out_res.wrote_reg;
    assign o_out.dest_reg    = w_out_res.dest_reg;
    assign o_out.write_value = w_out_res.write_value;
    assign o_out.stored      = w_out_res.stored;
    assign o_out.store_index = w_out_res.store_index;
    assign o_out.unknown_op  = w_out_res.unknown_op;

endmodule

[hw/rtl/mse_regfile.sv]
// ----------------------------------------------------------------------------
// mse_regfile
// 32 x 32 register file, one write port, two registered read ports.
// Per-entry valid bits make unwritten registers read as zero after reset.
// ----------------------------------------------------------------------------
module mse_regfile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mse_pkg::REG_AW-1:0]  i_rs_addr,
    input  logic [mse_pkg::REG_AW-1:0]  i_rt_addr,
    input  logic                        i_we,
    input  logic [mse_pkg::REG_AW-1:0]  i_waddr,
    input  logic [mse_pkg::WORD_W-1:0]  i_wdata,
    output logic [mse_pkg::WORD_W-1:0]  o_rs_data,
    output logic [mse_pkg::WORD_W-1:0]  o_rt_data
);
    import mse_pkg::*;

    logic [WORD_W-1:0]  r_mem [REG_NUM];
    logic [REG_NUM-1:0] r_vld;
    logic [WORD_W-1:0]  r_rs_q;
    logic [WORD_W-1:0]  r_rt_q;
    logic               r_rs_v;
    logic               r_rt_v;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rs_q <= r_mem[i_rs_addr];
        r_rt_q <= r_mem[i_rt_addr];
        r_rs_v <= r_vld[i_rs_addr];
        r_rt_v <= r_vld[i_rt_addr];
    end

    // register 0 is never written, so its valid bit stays low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    assign o_rs_data = r_rs_v ? r_rs_q : '0;
    assign o_rt_data = r_rt_v ? r_rt_q : '0;

endmodule

[hw/rtl/mse_dstore.sv]
// ----------------------------------------------------------------------------
// mse_dstore
// Data store memory with one write port and one registered read port.
// A clearing pass after reset writes zero to every word.
// ----------------------------------------------------------------------------
module mse_dstore #(
    parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [$clog2(DATA_WORDS)-1:0] i_waddr,
    input  logic [mse_pkg::WORD_W-1:0]    i_wdata,
    input  logic [$clog2(DATA_WORDS)-1:0] i_raddr,
    output logic [mse_pkg::WORD_W-1:0]    o_rdata,
    output logic                          o_busy
);
    import mse_pkg::*;

    localparam int unsigned AW = $clog2(DATA_WORDS);

    logic [WORD_W-1:0] r_mem [DATA_WORDS];
    logic [WORD_W-1:0] r_rdata;
    logic              r_busy;
    logic [AW-1:0]     r_clr_idx;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(DATA_WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign w_we    = r_busy || i_we;
    assign w_waddr = r_busy ? r_clr_idx : i_waddr;
    assign w_wdata = r_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

[hw/rtl/mse_idx_mod.sv]
// ----------------------------------------------------------------------------
// mse_idx_mod
// Reduces a word address or load index modulo the data store depth. Inputs
// that fit pass through; power-of-two depths take the low bits; others sum
// per-byte residues from constant tables, then subtract one depth multiple.
// ----------------------------------------------------------------------------
module mse_idx_mod #(
    parameter int unsigned IN_W  = mse_pkg::WADDR_W,
    parameter int unsigned DEPTH = mse_pkg::DATA_WORDS_DEF
) (
    input  logic [IN_W-1:0]          i_val,
    output logic [$clog2(DEPTH)-1:0] o_idx
);
    import mse_pkg::*;

    localparam int unsigned AW     = $clog2(DEPTH);
    localparam bit          FITS   = (64'd1 << IN_W) <= 64'(DEPTH);
    localparam bit          POW2   = (DEPTH & (DEPTH - 1)) == 0;
    localparam int unsigned NCH    = (IN_W + 7) / 8;
    localparam int unsigned PAD_W  = NCH * 8;
    localparam int unsigned SW     = AW + $clog2(NCH) + 1;

    if (FITS) begin : g_fits
        assign o_idx = AW'(i_val);
    end else if (POW2) begin : g_pow2
        assign o_idx = i_val[AW-1:0];
    end else begin : g_tab
        logic [AW-1:0]    tab [NCH][256];
        logic [PAD_W-1:0] pad;
        logic [SW-1:0]    sum;
        logic [SW-1:0]    red;

        for (genvar c = 0; c < NCH; c++) begin : g_chunk
            for (genvar b = 0; b < 256; b++) begin : g_ent
                assign tab[c][b] = AW'(mse_residue(b, 8 * c, DEPTH));
            end
        end

        assign pad = PAD_W'(i_val);

        // sum stays below NCH * DEPTH, so one subtract of a multiple finishes it
        always_comb begin
            sum = '0;
            for (int c = 0; c < NCH; c++) begin
                sum = sum + SW'(tab[c][pad[8*c +: 8]]);
            end
            red = sum;
            for (int k = 1; k < NCH; k++) begin
                if (sum >= SW'(k * DEPTH)) red = sum - SW'(k * DEPTH);
            end
        end

        assign o_idx = red[AW-1:0];
    end

endmodule

[hw/rtl/mse_exec.sv]
// ----------------------------------------------------------------------------
// mse_exec
// Decode and execute of one instruction: ALU, compare, branch and jump
// target, and load/store word address.
// ----------------------------------------------------------------------------
module mse_exec (
    input  logic                        i_mode,
    input  logic [mse_pkg::WORD_W-1:0]  i_instr,
    input  logic [mse_pkg::PC_W-1:0]    i_pc,
    input  logic [mse_pkg::WORD_W-1:0]  i_a,
    input  logic [mse_pkg::WORD_W-1:0]  i_b,
    output mse_pkg::t_ex                o_ex
);
    import mse_pkg::*;

    logic [5:0]        op;
    logic [5:0]        fn;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] rd;
    logic [4:0]        sh;
    logic [15:0]       imm;
    logic [WORD_W-1:0] simm;
    logic [WORD_W-1:0] zimm;
    logic [WORD_W-1:0] addr;
    logic [PC_W-1:0]   pc_inc;
    logic              a_lt_b_s;
    logic              a_lt_b_u;
    logic              a_lt_i_s;
    logic              a_lt_i_u;
    t_ex               ex;

    assign op   = i_instr[31:26];
    assign rt   = i_instr[20:16];
    assign rd   = i_instr[15:11];
    assign sh   = i_instr[10:6];
    assign fn   = i_instr[5:0];
    assign imm  = i_instr[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign zimm = {16'h0000, imm};
    assign addr = i_a + simm;
    assign pc_inc = i_pc + 1'b1;

    assign a_lt_b_s = $signed(i_a) < $signed(i_b);
    assign a_lt_b_u = i_a < i_b;
    assign a_lt_i_s = $signed(i_a) < $signed(simm);
    assign a_lt_i_u = i_a < simm;

    always_comb begin
        ex           = '0;
        ex.npc       = pc_inc;
        ex.word_addr = addr[31:2];
        if (i_mode) begin
            ex.npc = i_pc;
        end else begin
            unique case (op)
                OP_RTYPE: begin
                    ex.wr  = 1'b1;
                    ex.dst = rd;
                    unique case (fn)
                        FN_ADD, FN_ADDU: ex.val = i_a + i_b;
                        FN_SUB, FN_SUBU: ex.val = i_a - i_b;
                        FN_AND:          ex.val = i_a & i_b;
                        FN_OR:           ex.val = i_a | i_b;
                        FN_SLT:          ex.val = WORD_W'(a_lt_b_s);
                        FN_SLTU:         ex.val = WORD_W'(a_lt_b_u);
                        FN_SLL:          ex.val = i_b << sh;
                        FN_SRL:          ex.val = i_b >> sh;
                        default: begin
                            ex.wr  = 1'b0;
                            ex.unk = 1'b1;
                        end
                    endcase
                end
                OP_ADDI, OP_ADDIU: begin
                    ex.wr  = 1'b1;
                    ex.dst = rt;
                    ex.val = addr;
                end
                OP_ANDI: begin
                    ex.wr  = 1'b1;
                    ex.dst = rt;
                    ex.val = i_a & zimm;
                end
                OP_ORI: begin
                    ex.wr  = 1'b1;
                    ex.dst = rt;
                    ex.val = i_a | zimm;
                end
                OP_SLTI: begin
                    ex.wr  = 1'b1;
                    ex.dst = rt;
                    ex.val = WORD_W'(a_lt_i_s);
                end
                OP_SLTIU: begin
                    ex.wr  = 1'b1;
                    ex.dst = rt;
                    ex.val = WORD_W'(a_lt_i_u);
                end
                OP_LUI: begin
                    ex.wr  = 1'b1;
                    ex.dst = rt;
                    ex.val = {imm, 16'h0000};
                end
                OP_LW: begin
                    ex.wr    = 1'b1;
                    ex.dst   = rt;
                    ex.lw_wb = 1'b1;
                    ex.mem   = 1'b1;
                end
                OP_SW: begin
                    ex.st  = 1'b1;
                    ex.mem = 1'b1;
                end
                OP_BEQ, OP_BNE: begin
                    if ((op == OP_BEQ) == (i_a == i_b)) begin
                        ex.npc = pc_inc + simm[PC_W-1:0];
                    end
                end
                OP_J: begin
                    ex.npc = i_instr[PC_W-1:0];
                end
                OP_JAL: begin
                    ex.wr  = 1'b1;
                    ex.dst = REG_LINK;
                    ex.val = WORD_W'(pc_inc);
                    ex.npc = i_instr[PC_W-1:0];
                end
                default: begin
                    ex.unk = 1'b1;
                end
            endcase
            // writes to register zero are dropped and not reported
            if (!ex.wr || ex.dst == '0) begin
                ex.wr    = 1'b0;
                ex.dst   = '0;
                ex.val   = '0;
                ex.lw_wb = 1'b0;
            end
        end
    end

    assign o_ex = ex;

endmodule

[hw/rtl/mse_res_fifo.sv]
// ----------------------------------------------------------------------------
// mse_res_fifo
// Small result queue between the writeback stage and the output channel.
// ----------------------------------------------------------------------------
module mse_res_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mse_pkg::t_res   i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output mse_pkg::t_res   o_data
);
    import mse_pkg::*;

    t_res              r_mem [RES_DEPTH];
    logic [RES_PW-1:0] r_wp;
    logic [RES_PW-1:0] r_rp;
    logic [RES_CW-1:0] r_cnt;
    logic [RES_CW-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

endmodule

[hw/rtl/mse_checker.sv]
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks for the execute block, bound to the top level.
// ----------------------------------------------------------------------------
module mse_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_wrote_reg,
    input logic [mse_pkg::REG_AW-1:0]  i_dest_reg,
    input logic [mse_pkg::WORD_W-1:0]  i_write_value,
    input logic                        i_stored,
    input logic                        i_unknown_op
);
    import mse_pkg::*;

    // store clearing pass keeps input closed right after reset
    a_ready_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    a_no_result_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    a_store_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_stored && i_wrote_reg))
        else $error("store and register write in one result");

    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_wrote_reg) |-> (i_dest_reg == '0 && i_write_value == '0))
        else $error("destination or value set without register write");

    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_unknown_op) |-> (!i_wrote_reg && !i_stored))
        else $error("unknown instruction had a side effect");

endmodule

bind mips_subset_execute mse_checker u_mse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_wrote_reg   (o_out.wrote_reg),
    .i_dest_reg    (o_out.dest_reg),
    .i_write_value (o_out.write_value),
    .i_stored      (o_out.stored),
    .i_unknown_op  (o_out.unknown_op)
);
